[design/yrr_pkg.sv]
// Shared types and constants for the YUV to RGBA pixel converter with rotated index.
// No dependencies; every other design file refers to this package by scoped name.
`default_nettype none

package yrr_pkg;

  localparam int MaxDim    = 4096;
  localparam int CoordW    = $clog2(MaxDim);
  localparam int HeightW   = CoordW + 1;
  localparam int SampleW   = 8;
  localparam int IndexW    = 24;
  localparam int PixelW    = 32;
  localparam int ProductW  = 2 * HeightW;
  localparam int ColorW    = 11;

  localparam logic [HeightW-1:0] HeightReset = HeightW'(480);
  localparam logic [SampleW-1:0] AlphaOpaque = 8'hFF;

  typedef struct packed {
    logic [CoordW-1:0]  column;
    logic [CoordW-1:0]  row;
    logic [SampleW-1:0] luma;
    logic [SampleW-1:0] chroma_blue;
    logic [SampleW-1:0] chroma_red;
  } pixel_t;

  typedef struct packed {
    logic [IndexW-1:0] dest_index;
    logic [PixelW-1:0] packed_pixel;
  } result_t;

endpackage

`default_nettype wire

[design/yrr_color.sv]
// YUV to packed RGBA conversion with fixed coefficients and byte clamping.
// Depends on yrr_pkg for sample widths and the alpha constant.
`default_nettype none

module yrr_color (
  input  wire logic [yrr_pkg::SampleW-1:0] luma,
  input  wire logic [yrr_pkg::SampleW-1:0] chroma_blue,
  input  wire logic [yrr_pkg::SampleW-1:0] chroma_red,
  output logic      [yrr_pkg::PixelW-1:0]  packed_pixel
);

  localparam int W = yrr_pkg::ColorW;

  localparam logic [18:0] CoefRedV   = 19'd1436;
  localparam logic [23:0] CoefGreenU = 24'd46549;
  localparam logic [24:0] CoefGreenV = 25'd93604;
  localparam logic [18:0] CoefBlueU  = 19'd1814;

  localparam logic signed [W-1:0] OffsRed   = W'(179);
  localparam logic signed [W-1:0] OffsGreen = W'(44 + 91);
  localparam logic signed [W-1:0] OffsBlue  = W'(227);

  logic [18:0] prod_rv;
  logic [23:0] prod_gu;
  logic [24:0] prod_gv;
  logic [18:0] prod_bu;

  logic signed [W-1:0] y_s;
  logic signed [W-1:0] red_sum;
  logic signed [W-1:0] green_sum;
  logic signed [W-1:0] blue_sum;

  function automatic logic [yrr_pkg::SampleW-1:0] clamp_byte(input logic signed [W-1:0] v);
    logic [yrr_pkg::SampleW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > W'(255)) begin
      res = '1;
    end else begin
      res = v[yrr_pkg::SampleW-1:0];
    end
    return res;
  endfunction

  assign prod_rv = 19'(chroma_red)  * CoefRedV;
  assign prod_gu = 24'(chroma_blue) * CoefGreenU;
  assign prod_gv = 25'(chroma_red)  * CoefGreenV;
  assign prod_bu = 19'(chroma_blue) * CoefBlueU;

  assign y_s = $signed(W'(luma));

  // Truncating shifts: keep only the integer part of each scaled product.
  assign red_sum   = y_s + $signed(W'(prod_rv[18:10])) - OffsRed;
  assign green_sum = y_s - $signed(W'(prod_gu[23:17])) - $signed(W'(prod_gv[24:17]))
                     + OffsGreen;
  assign blue_sum  = y_s + $signed(W'(prod_bu[18:10])) - OffsBlue;

  assign packed_pixel = {yrr_pkg::AlphaOpaque, clamp_byte(blue_sum),
                         clamp_byte(green_sum), clamp_byte(red_sum)};

endmodule

`default_nettype wire

[design/yrr_index.sv]
// Destination word index in the image rotated by 90 degrees: height*(column+1)-row-1.
// Depends on yrr_pkg for coordinate and index widths; wraps modulo 2^IndexW.
`default_nettype none

module yrr_index (
  input  wire logic [yrr_pkg::HeightW-1:0] image_height,
  input  wire logic [yrr_pkg::CoordW-1:0]  column,
  input  wire logic [yrr_pkg::CoordW-1:0]  row,
  output logic      [yrr_pkg::IndexW-1:0]  dest_index
);

  logic [yrr_pkg::HeightW-1:0]  col_plus;
  logic [yrr_pkg::ProductW-1:0] product;

  assign col_plus = yrr_pkg::HeightW'(column) + yrr_pkg::HeightW'(1);
  assign product  = yrr_pkg::ProductW'(image_height) * yrr_pkg::ProductW'(col_plus);

  // Drop the high product bits; a row past height*(column+1)-1 wraps around.
  assign dest_index = product[yrr_pkg::IndexW-1:0] - yrr_pkg::IndexW'(row)
                      - yrr_pkg::IndexW'(1);

endmodule

`default_nettype wire

[design/yuv_to_rgba_rotate_pixel_core.sv]
// Path: pixel beat, input register, color and index logic, result register, result beat.
// Throughput: one pixel per cycle while result_ready stays high.
// A stalled result holds in the result register while the input register takes one more beat.
// Reset (rst, synchronous, active high) empties both stages and sets image_height to 480.
// Configuration writes are taken in any cycle; write only while no pixel is in flight.
// Depends on yrr_pkg, yrr_color and yrr_index.
`default_nettype none

module yuv_to_rgba_rotate_pixel_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [yrr_pkg::HeightW-1:0] cfg_data,
  input  wire logic                        pixel_valid,
  output logic                             pixel_ready,
  input  wire yrr_pkg::pixel_t             pixel,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output yrr_pkg::result_t                 result
);

  logic [yrr_pkg::HeightW-1:0] image_height;
  logic                        stage_valid;
  yrr_pkg::pixel_t             stage_pixel;
  logic                        result_load;
  yrr_pkg::result_t            result_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= yrr_pkg::HeightReset;
    end else if (cfg_valid && cfg_ready) begin
      image_height <= cfg_data;
    end
  end

  // Advance the result stage when it is empty or its beat is being taken.
  assign result_load = !result_valid || result_ready;
  assign pixel_ready = !stage_valid || result_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (pixel_ready) begin
      stage_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_ready && pixel_valid) begin
      stage_pixel <= pixel;
    end
  end

  yrr_index u_index (
    .image_height (image_height),
    .column       (stage_pixel.column),
    .row          (stage_pixel.row),
    .dest_index   (result_next.dest_index)
  );

  yrr_color u_color (
    .luma         (stage_pixel.luma),
    .chroma_blue  (stage_pixel.chroma_blue),
    .chroma_red   (stage_pixel.chroma_red),
    .packed_pixel (result_next.packed_pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load && stage_valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

[design/yrr_checker.sv]
// Port-level checks for yuv_to_rgba_rotate_pixel_core, bound to every instance.
// Depends on yrr_pkg for the result type.
`default_nettype none

module yrr_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             pixel_ready,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire yrr_pkg::result_t result
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result beat changed");

  // With the result stage empty the input stage can always drain.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> pixel_ready)
    else $error("pixel_ready low with empty result stage");

  // Alpha is always opaque.
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.packed_pixel[31:24] == 8'hFF))
    else $error("alpha byte not opaque");

endmodule

bind yuv_to_rgba_rotate_pixel_core yrr_checker u_yrr_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_ready  (pixel_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire

[tb/tb_yuv_to_rgba_rotate_pixel_core.sv]
// Self-checking bench for yuv_to_rgba_rotate_pixel_core: a directed table, then random pixels
// over several image heights, each result checked against its typed value or a local color and index predictor.
// Depends on yrr_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_yuv_to_rgba_rotate_pixel_core;

  typedef struct packed {
    logic                        write_height;
    logic [yrr_pkg::HeightW-1:0] height;
    logic [yrr_pkg::CoordW-1:0]  column;
    logic [yrr_pkg::CoordW-1:0]  row;
    logic [yrr_pkg::SampleW-1:0] luma;
    logic [yrr_pkg::SampleW-1:0] chroma_blue;
    logic [yrr_pkg::SampleW-1:0] chroma_red;
    logic                        typed;
    logic [yrr_pkg::IndexW-1:0]  want_index;
    logic [yrr_pkg::PixelW-1:0]  want_pixel;
  } stim_row_t;

  localparam int NumDirected  = 18;
  localparam int NumPhases    = 8;
  localparam int PhaseItems   = 150;
  localparam int LongHold     = 400;
  localparam int DrainLimit   = 20000;

  // Typed rows: reset height, sample extremes, rows at or past the height, height zero,
  // and products that wrap past the 24-bit index.
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{1'b0, 13'd0,    12'd0,    12'd0,    8'd0,   8'd0,   8'd0,   1'b1, 24'h0001DF, 32'hFF008700},
    '{1'b0, 13'd0,    12'd0,    12'd0,    8'd128, 8'd128, 8'd128, 1'b1, 24'h0001DF, 32'hFF7F7F80},
    '{1'b0, 13'd0,    12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 1'b1, 24'h1DF000, 32'hFFFF76FF},
    '{1'b0, 13'd0,    12'd0,    12'd479,  8'd0,   8'd0,   8'd255, 1'b1, 24'h000000, 32'hFF0000B2},
    '{1'b0, 13'd0,    12'd0,    12'd4095, 8'd0,   8'd255, 8'd0,   1'b1, 24'hFFF1E0, 32'hFFE02D00},
    '{1'b0, 13'd0,    12'd100,  12'd200,  8'd255, 8'd0,   8'd0,   1'b1, 24'h00BC97, 32'hFF1CFF4C},
    '{1'b0, 13'd0,    12'd2730, 12'd1365, 8'hAA,  8'h55,  8'h0F,  1'b0, 24'h0,      32'h0},
    '{1'b0, 13'd0,    12'd1365, 12'd2730, 8'h55,  8'hAA,  8'hF0,  1'b0, 24'h0,      32'h0},
    '{1'b1, 13'd0,    12'd0,    12'd0,    8'd0,   8'd0,   8'd0,   1'b1, 24'hFFFFFF, 32'hFF008700},
    '{1'b0, 13'd0,    12'd4095, 12'd4095, 8'd128, 8'd128, 8'd128, 1'b1, 24'hFFF000, 32'hFF7F7F80},
    '{1'b1, 13'd1,    12'd0,    12'd0,    8'd255, 8'd255, 8'd255, 1'b1, 24'h000000, 32'hFFFF76FF},
    '{1'b0, 13'd0,    12'd4095, 12'd0,    8'd17,  8'd200, 8'd90,  1'b0, 24'h0,      32'h0},
    '{1'b1, 13'd8191, 12'd4095, 12'd0,    8'd0,   8'd0,   8'd0,   1'b1, 24'hFFEFFF, 32'hFF008700},
    '{1'b0, 13'd0,    12'd4095, 12'd4095, 8'd255, 8'd0,   8'd0,   1'b0, 24'h0,      32'h0},
    '{1'b1, 13'd4096, 12'd4095, 12'd4095, 8'd128, 8'd128, 8'd128, 1'b1, 24'hFFF000, 32'hFF7F7F80},
    '{1'b0, 13'd0,    12'd0,    12'd4095, 8'd255, 8'd255, 8'd255, 1'b1, 24'h000000, 32'hFFFF76FF},
    '{1'b0, 13'd0,    12'd2048, 12'd100,  8'd60,  8'd200, 8'd30,  1'b0, 24'h0,      32'h0},
    '{1'b1, 13'd480,  12'd639,  12'd479,  8'd0,   8'd255, 8'd0,   1'b0, 24'h0,      32'h0}
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [yrr_pkg::HeightW-1:0] cfg_data = '0;
  logic                        pixel_valid = 1'b0;
  logic                        pixel_ready;
  yrr_pkg::pixel_t             pixel = '0;
  logic                        result_valid;
  logic                        result_ready = 1'b0;
  yrr_pkg::result_t            result;

  logic [yrr_pkg::HeightW-1:0] image_height = yrr_pkg::HeightReset;
  yrr_pkg::result_t            pending_results [$];
  logic                        typed_flag = 1'b0;
  yrr_pkg::result_t            typed_value = '0;
  logic                        steady_flow = 1'b0;
  logic                        hold_request = 1'b0;
  int                          error_count = 0;

  yuv_to_rgba_rotate_pixel_core DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] clamp_to_byte(int value);
    if (value < 0) return 8'd0;
    if (value > 255) return 8'd255;
    return value[7:0];
  endfunction

  function automatic yrr_pkg::result_t convert_pixel(yrr_pkg::pixel_t p,
                                                     logic [yrr_pkg::HeightW-1:0] height);
    int               y;
    int               u;
    int               v;
    logic [31:0]      index;
    yrr_pkg::result_t r;
    y = p.luma;
    u = p.chroma_blue;
    v = p.chroma_red;
    // Wrap freely: rows past height*(column+1)-1 and height zero give negative indexes.
    index = 32'(height) * (32'(p.column) + 32'd1) - 32'(p.row) - 32'd1;
    r.dest_index = index[yrr_pkg::IndexW-1:0];
    r.packed_pixel = {yrr_pkg::AlphaOpaque,
                      clamp_to_byte(y + ((u * 1814) >> 10) - 227),
                      clamp_to_byte(y - ((u * 46549) >> 17) + 44 - ((v * 93604) >> 17) + 91),
                      clamp_to_byte(y + ((v * 1436) >> 10) - 179)};
    return r;
  endfunction

  function automatic logic [7:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Lower pixel valid and wait until every expected result beat has come back or the drain limit is reached.
  task automatic wait_until_drained();
    int waited = 0;
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
  endtask

  task automatic write_image_height(logic [yrr_pkg::HeightW-1:0] height);
    wait_until_drained();
    cfg_valid <= 1'b1;
    cfg_data <= height;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    image_height = height;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic offer_pixel(yrr_pkg::pixel_t p, logic typed, yrr_pkg::result_t want);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_flag = typed;
    typed_value = want;
    pixel_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
  endtask

  // Scoreboard: check result beats first, then queue the prediction for a new pixel beat.
  always @(posedge clk) begin : scoreboard
    yrr_pkg::result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing expected", result.packed_pixel, '0);
        end else begin
          want = pending_results.pop_front();
          if (result.dest_index !== want.dest_index)
            report_mismatch("dest_index", 32'(result.dest_index), 32'(want.dest_index));
          if (result.packed_pixel !== want.packed_pixel)
            report_mismatch("packed_pixel", result.packed_pixel, want.packed_pixel);
        end
      end
      if (pixel_valid && pixel_ready)
        pending_results.push_back(typed_flag ? typed_value : convert_pixel(pixel, image_height));
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin : result_sink
    int stall;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LongHold;
      end else if (steady_flow) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 5);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    stim_row_t                   entry;
    yrr_pkg::pixel_t             p;
    logic [yrr_pkg::HeightW-1:0] heights [NumPhases];
    int                          row_span;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (DirectedRows[i]) begin
      entry = DirectedRows[i];
      if (entry.write_height) write_image_height(entry.height);
      p = '{entry.column, entry.row, entry.luma, entry.chroma_blue, entry.chroma_red};
      offer_pixel(p, entry.typed, '{entry.want_index, entry.want_pixel});
    end

    heights = '{13'($urandom_range(1, 8191)), 13'd1, 13'd8191, 13'd0, 13'd4096,
                13'($urandom_range(2, 600)), yrr_pkg::HeightReset,
                13'($urandom_range(1, 4095))};
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_image_height(heights[ph]);
      row_span = (heights[ph] > 4096) ? 4096 : heights[ph];
      for (int n = 0; n < PhaseItems; n++) begin
        steady_flow = (n >= 50 && n < 90);
        if (ph == 1 && n == 20) hold_request = 1'b1;
        if (ph == 2 && n == 75) wait_until_drained();
        // Keep most rows inside the image; the rest cover the wrapping index.
        if (row_span > 0 && $urandom_range(0, 9) < 8)
          p.row = 12'($urandom_range(0, row_span - 1));
        else
          p.row = 12'($urandom_range(0, 4095));
        case ($urandom_range(0, 9))
          0: p.column = '0;
          1: p.column = '1;
          default: p.column = 12'($urandom_range(0, 4095));
        endcase
        p.luma = draw_sample();
        p.chroma_blue = draw_sample();
        p.chroma_red = draw_sample();
        offer_pixel(p, 1'b0, '0);
      end
    end
    steady_flow = 1'b0;

    wait_until_drained();
    repeat (10) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never returned", 32'(pending_results.size()), '0);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
design/yrr_pkg.sv
design/yrr_color.sv
design/yrr_index.sv
design/yuv_to_rgba_rotate_pixel_core.sv
design/yrr_checker.sv
tb/tb_yuv_to_rgba_rotate_pixel_core.sv
